>>> sv/slid_pkg.sv
// Package for the sorted key table: default sizes, status and operation codes,
// and the per-cell flag and command types. Depends on nothing.
`default_nettype none

package slid_pkg;

  // Default sizes and fixed field widths
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int IN_KEY_W     = 16;
  localparam int OUT_KEY_W    = 16;
  localparam int OUT_COUNT_W  = 5;
  localparam int STATUS_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  // What a cell reports to its neighbors and to the top
  typedef struct packed {
    logic valid;
    logic gt;   // stored key greater than the incoming key
    logic eq;   // stored key equal to the incoming key
  } cell_flag_t;

  // Row-wide command for the current beat
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> sv/slid_if.sv
// Handshake interfaces for the operation and result channels.
// Depends on slid_pkg for the field widths.
`default_nettype none

interface slid_in_if;
  import slid_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic signed [IN_KEY_W-1:0]  key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface slid_out_if;
  import slid_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [STATUS_W-1:0]           status;
  logic [OUT_COUNT_W-1:0]        entry_count;
  logic signed [OUT_KEY_W-1:0]   smallest_key;
  logic signed [OUT_KEY_W-1:0]   largest_key;

  modport source (output valid, output status, output entry_count,
                  output smallest_key, output largest_key, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input smallest_key, input largest_key, output ready);
endinterface

`default_nettype wire

>>> sv/slid_cell.sv
// One cell of the sorted row: holds a key and its valid bit, compares against
// the incoming key and shifts with its neighbors. Depends on slid_pkg.
`default_nettype none

module slid_cell #(
  parameter int KEY_BITS = slid_pkg::KEY_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire slid_pkg::cell_cmd_t        cmd_i,
  input  wire logic signed [KEY_BITS-1:0] key_i,
  input  wire slid_pkg::cell_flag_t       left_flag_i,
  input  wire logic signed [KEY_BITS-1:0] left_key_i,
  input  wire logic                       right_valid_i,
  input  wire logic signed [KEY_BITS-1:0] right_key_i,
  output slid_pkg::cell_flag_t            flag_o,
  output logic signed [KEY_BITS-1:0]      key_o
);
  import slid_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;

  // Local compare against the key on the bus
  assign flag_o.valid = valid_q;
  assign flag_o.gt    = valid_q && (key_q > key_i);
  assign flag_o.eq    = valid_q && (key_q == key_i);
  assign key_o        = key_q;

  // Insert: left neighbor moving right pushes its key in; the first cell that
  // is empty or greater takes the new key. Delete: cells at or past the match
  // pull from the right.
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      if (!left_flag_i.valid || left_flag_i.gt) begin
        if (left_flag_i.valid) begin
          key_d   = left_key_i;
          valid_d = 1'b1;
        end
      end else if (!valid_q || flag_o.gt) begin
        key_d   = key_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.del) begin
      if (flag_o.gt || flag_o.eq) begin
        key_d   = right_key_i;
        valid_d = right_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

>>> sv/sorted_list_insert_delete_core.sv
// Sorted key table top level: a row of compare-and-shift cells, entry count,
// and the result register. Depends on slid_pkg, slid_if and slid_cell.
//
//   channel   dir   payload                                           handshake
//   in_i      in    operation, key                                    valid/ready
//   out_o     out   status, entry_count, smallest_key, largest_key    valid/ready
//
// For each operation the cells compare and shift in the beat's
// cycle, and the next cycle reads the ends of the row into the result register.
// A new beat is taken once that result is formed and the result slot is free
// or draining in the same cycle. Reset clears the count and all valid bits;
// stored keys are not reset. A stalled result holds and blocks new beats.
`default_nettype none

module sorted_list_insert_delete_core #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = slid_pkg::KEY_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slid_in_if.sink     in_i,
  slid_out_if.source  out_o
);
  import slid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                        busy_q;
  logic                        out_valid_q;
  logic [CNT_W-1:0]            count_q;
  status_e                     status_q;
  logic [STATUS_W-1:0]         res_status_q;
  logic [OUT_COUNT_W-1:0]      res_count_q;
  logic signed [OUT_KEY_W-1:0] res_small_q, res_large_q;

  logic                        accept;
  logic                        full, found;
  logic signed [KEY_BITS-1:0]  key_w;
  cell_cmd_t                   cmd;
  cell_flag_t                  flag   [CAPACITY];
  logic signed [KEY_BITS-1:0]  key_row[CAPACITY];
  logic [CAPACITY-1:0]         valid_vec, eq_vec, last_vec;
  logic signed [KEY_BITS-1:0]  large_key;

  // Input key wrapped or sign-extended to the stored width
  assign key_w  = KEY_BITS'(in_i.key);
  assign accept = in_i.valid && in_i.ready;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign found  = |eq_vec;

  assign in_i.ready = !busy_q && (!out_valid_q || out_o.ready);

  assign cmd.ins = accept && (op_e'(in_i.operation) == OP_INSERT) && !full;
  assign cmd.del = accept && (op_e'(in_i.operation) == OP_DELETE) && found;

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_flag_t                 lf;
    logic signed [KEY_BITS-1:0] lk;
    logic                       rv;
    logic signed [KEY_BITS-1:0] rk;
    if (g == 0) begin : g_head
      assign lf = '{valid: 1'b1, gt: 1'b0, eq: 1'b0};
      assign lk = '0;
    end else begin : g_mid
      assign lf = flag[g-1];
      assign lk = key_row[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rk = '0;
    end else begin : g_body
      assign rv = flag[g+1].valid;
      assign rk = key_row[g+1];
    end

    slid_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .key_i         (key_w),
      .left_flag_i   (lf),
      .left_key_i    (lk),
      .right_valid_i (rv),
      .right_key_i   (rk),
      .flag_o        (flag[g]),
      .key_o         (key_row[g])
    );

    assign valid_vec[g] = flag[g].valid;
    assign eq_vec[g]    = flag[g].eq;
  end

  // Last valid cell; its key is the largest, zero when the row is empty
  assign last_vec = valid_vec & ~({1'b0, valid_vec[CAPACITY-1:1]});

  always_comb begin
    large_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_vec[i]) begin
        large_key = large_key | key_row[i];
      end
    end
  end

  // Count, status and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= ST_DONE;
    end else begin
      busy_q <= accept;
      if (cmd.ins) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd.del) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (accept) begin
        if (op_e'(in_i.operation) == OP_INSERT) begin
          status_q <= full ? ST_FULL : ST_DONE;
        end else begin
          status_q <= found ? ST_DONE : ST_NOT_FOUND;
        end
      end
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, formed from the updated row
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_status_q <= status_q;
      res_count_q  <= OUT_COUNT_W'(count_q);
      res_small_q  <= valid_vec[0] ? OUT_KEY_W'(key_row[0]) : '0;
      res_large_q  <= OUT_KEY_W'(large_key);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_status_q;
  assign out_o.entry_count  = res_count_q;
  assign out_o.smallest_key = res_small_q;
  assign out_o.largest_key  = res_large_q;

  logic [CAPACITY:0] valid_plus;
  assign valid_plus = {1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1};

`ifndef NO_ASSERTIONS
  // Occupied cells form a solid run from the head of the row
  a_packed_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(valid_plus))
    else $error("occupied cells not contiguous");

  // Count tracks the number of occupied cells
  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("entry count differs from occupied cells");

  // Every accepted beat yields a result, through busy_q and then out_valid_q
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 out_valid_q)
    else $error("result not produced after accepted beat");

  // No new beat while the row is being read out
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept)
    else $error("beat accepted during readout");
`endif

endmodule

`default_nettype wire
